// File: rtl/core/b64lrc_pkg.sv
// Shared constants and types of the base64 LRC frame receiver.
package b64lrc_pkg;

   localparam int MAX_FRAME_CHARS = 384;
   localparam int CHAR_W = $clog2(MAX_FRAME_CHARS + 1);
   localparam int DEC_W  = $clog2((MAX_FRAME_CHARS / 4) * 3 + 1);
   localparam int LEN_W  = 9;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] START_CODE_RESET = 8'h02;
   localparam logic [7:0] END_CODE_RESET   = 8'h03;

   // register indexes of the csr port
   localparam logic [7:0] CSR_START_CODE = 8'd0;
   localparam logic [7:0] CSR_END_CODE   = 8'd1;

   // frame status codes; ST_OK doubles as "no error recorded"
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BAD   = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_LRC   = 3'd3;
   localparam logic [2:0] ST_OVER  = 3'd4;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] end_code;
   } cfg_type;

   // one queued command: a status item, or one to three payload bytes
   typedef struct packed {
      logic             is_status;
      logic [1:0]       count;
      logic [2:0][7:0]  bytes;
      logic [2:0]       status;
      logic [LEN_W-1:0] length;
   } entry_type;

endpackage

// File: rtl/core/b64lrc_front.sv
// Front end: frame tracking, base64 decode, LRC hold-back and command generation.
module b64lrc_front (
   input  logic                clock,
   input  logic                reset,
   input  b64lrc_pkg::cfg_type cfg,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output logic                push,
   output b64lrc_pkg::entry_type push_entry
);
   import b64lrc_pkg::*;

   localparam logic [6:0] SX_BAD = 7'd64;
   localparam logic [6:0] SX_PAD = 7'd65;
   localparam logic [CHAR_W-1:0] MAX_CHARS = CHAR_W'(MAX_FRAME_CHARS);

   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = SX_BAD;
      if (c >= 8'h41 && c <= 8'h5a) r = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7a) r = 7'(c - 8'h61) + 7'd26;
      else if (c >= 8'h30 && c <= 8'h39) r = 7'(c - 8'h30) + 7'd52;
      else if (c == 8'h2b) r = 7'd62;
      else if (c == 8'h2f) r = 7'd63;
      else if (c == 8'h3d) r = SX_PAD;
      return r;
   endfunction

   logic              in_frame_ff, in_frame_in;
   logic [17:0]       acc_ff, acc_in;
   logic [1:0]        sc_ff, sc_in;
   logic [1:0]        pad_ff, pad_in;
   logic [CHAR_W-1:0] cc_ff, cc_in;
   logic [DEC_W-1:0]  dc_ff, dc_in;
   logic [7:0]        held_ff, held_in;
   logic [7:0]        xor_ff, xor_in;
   logic [2:0]        err_ff, err_in;

   logic [6:0]        sx;
   logic [5:0]        sv;
   logic              stop;
   logic [23:0]       quartet;
   logic [1:0]        nb;
   logic [1:0]        n;
   logic [DEC_W-1:0]  len_w;

   always_comb begin
      in_frame_in = in_frame_ff;
      acc_in      = acc_ff;
      sc_in       = sc_ff;
      pad_in      = pad_ff;
      cc_in       = cc_ff;
      dc_in       = dc_ff;
      held_in     = held_ff;
      xor_in      = xor_ff;
      err_in      = err_ff;
      push        = 1'b0;
      push_entry  = '0;
      sx          = sextet_of(rx_byte);
      sv          = sx[5:0];
      stop        = 1'b0;
      quartet     = {acc_ff, sx[5:0]};
      nb          = 2'd0;
      n           = 2'd0;
      len_w       = (dc_ff >= DEC_W'(3)) ? dc_ff - DEC_W'(3) : '0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == cfg.start_code) begin
               in_frame_in = 1'b1;
               acc_in = '0; sc_in = '0; pad_in = '0; cc_in = '0;
               dc_in = '0; held_in = '0; xor_in = '0; err_in = ST_OK;
            end
         end else if (rx_byte == cfg.end_code) begin
            // close the frame; first recorded error wins
            push = 1'b1;
            push_entry.is_status = 1'b1;
            push_entry.length = LEN_W'(len_w);
            if (err_ff != ST_OK) push_entry.status = err_ff;
            else if (sc_ff != 2'd0) push_entry.status = ST_BAD;
            else if (dc_ff < DEC_W'(3)) push_entry.status = ST_SHORT;
            else if (held_ff != xor_ff) push_entry.status = ST_LRC;
            else push_entry.status = ST_OK;
            in_frame_in = 1'b0;
            acc_in = '0; sc_in = '0; pad_in = '0; cc_in = '0;
            dc_in = '0; held_in = '0; xor_in = '0; err_in = ST_OK;
         end else if (err_ff != ST_OK) begin
            // drop everything up to the end code
         end else if (cc_ff >= MAX_CHARS) begin
            err_in = ST_OVER;
         end else begin
            cc_in = cc_ff + CHAR_W'(1);
            if (sx == SX_BAD) begin
               err_in = ST_BAD;
               stop = 1'b1;
            end else if (sx == SX_PAD) begin
               if (sc_ff < 2'd2) begin
                  err_in = ST_BAD;
                  stop = 1'b1;
               end else begin
                  if (sc_ff == 2'd2) pad_in = 2'd1;
                  else if (pad_ff != 2'd2) pad_in = pad_ff + 2'd1;
                  sv = 6'd0;
               end
            end else if (pad_ff != 2'd0) begin
               err_in = ST_BAD;
               stop = 1'b1;
            end
            if (!stop) begin
               if (sc_ff < 2'd3) begin
                  acc_in = {acc_ff[11:0], sv};
                  sc_in = sc_ff + 2'd1;
               end else begin
                  quartet = {acc_ff, sv};
                  nb = 2'd3 - pad_in;
                  // emit each byte one decode late; the final one is the LRC
                  for (int k = 0; k < 3; k++) begin
                     if (2'(k) < nb) begin
                        if (dc_in >= DEC_W'(3)) begin
                           push_entry.bytes[n] = held_in;
                           xor_in = xor_in ^ held_in;
                           n = n + 2'd1;
                        end
                        if (dc_in >= DEC_W'(2)) held_in = quartet[23 - 8 * k -: 8];
                        dc_in = dc_in + DEC_W'(1);
                     end
                  end
                  push_entry.count = n;
                  push = (n != 2'd0);
                  acc_in = '0;
                  sc_in = 2'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         acc_ff      <= '0;
         sc_ff       <= '0;
         pad_ff      <= '0;
         cc_ff       <= '0;
         dc_ff       <= '0;
         held_ff     <= '0;
         xor_ff      <= '0;
         err_ff      <= ST_OK;
      end else begin
         in_frame_ff <= in_frame_in;
         acc_ff      <= acc_in;
         sc_ff       <= sc_in;
         pad_ff      <= pad_in;
         cc_ff       <= cc_in;
         dc_ff       <= dc_in;
         held_ff     <= held_in;
         xor_ff      <= xor_in;
         err_ff      <= err_in;
      end
   end

endmodule

// File: rtl/core/b64lrc_queue.sv
// Short command queue between the decode front end and the output back end.
module b64lrc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64lrc_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output b64lrc_pkg::entry_type head_entry
);
   import b64lrc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: rtl/core/b64lrc_back.sv
// Back end: expands queued commands into result words through an output register.
module b64lrc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  b64lrc_pkg::entry_type       head_entry,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_item_kind,
   output logic [7:0]                  rsp_payload_byte,
   output logic [2:0]                  rsp_frame_status,
   output logic [b64lrc_pkg::LEN_W-1:0] rsp_payload_length,
   output logic                        rsp_run_last
);
   import b64lrc_pkg::*;

   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic             kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic [2:0]       status_ff, status_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             last_ff, last_in;
   logic             load;
   logic             last_of_entry;

   assign load = !valid_ff || !rsp_stall;
   assign last_of_entry = head_entry.is_status || ((idx_ff + 2'd1) == head_entry.count);
   assign pop = load && head_valid && last_of_entry;

   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      len_in    = len_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            kind_in   = head_entry.is_status;
            byte_in   = head_entry.is_status ? 8'd0 : head_entry.bytes[idx_ff];
            status_in = head_entry.is_status ? head_entry.status : ST_OK;
            len_in    = head_entry.is_status ? head_entry.length : '0;
            last_in   = last_of_entry;
            idx_in    = last_of_entry ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_item_kind      = kind_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_frame_status   = status_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_run_last       = last_ff;

endmodule

// File: rtl/core/base64_lrc_frame_receiver_unit.sv
// Top level of the base64 frame receiver with XOR LRC check.
//
//   channel | direction | handshake          | words
//   req_    | in        | req_valid/stall    | rx_byte
//   rsp_    | out       | rsp_valid/stall    | item_kind, payload_byte, frame_status,
//           |           |                    | payload_length, run_last
//   csr_    | in        | csr_valid/ready    | index, data (start_code, end_code)
//
// A byte is accepted and decoded in the front end in the same cycle; it
// leaves at most one queue command. The back end turns a command into one
// result word per cycle while rsp_stall is low, so a byte that decodes three
// payload bytes yields three result words; the rate is bound by the single
// result register. Reset is synchronous: it clears the frame state, the
// queue and the output valid, and restores the start and end codes.
// req_stall rises only while the two-entry queue is full; rsp_stall holds
// the output register, and the front end keeps taking bytes until the queue fills.
module base64_lrc_frame_receiver_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_frame_status,
   output logic [b64lrc_pkg::LEN_W-1:0] rsp_payload_length,
   output logic             rsp_run_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [7:0]       csr_data
);
   import b64lrc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      accept;
   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // csr writes land at once; indexes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_CODE: cfg_in.start_code = csr_data;
            CSR_END_CODE:   cfg_in.end_code   = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code <= START_CODE_RESET;
         cfg_ff.end_code   <= END_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold the serial side only when the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   b64lrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   b64lrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   b64lrc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_payload_length (rsp_payload_length),
      .rsp_run_last       (rsp_run_last)
   );

endmodule
